// ----- src/rvsm_pkg.sv -----
// Shared types, constants and the attenuation table of the stereo mixer.
package rvsm_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int REQ_W      = 2;
  localparam int WORD_W     = 32;
  localparam int VOL_W      = 23;   // unsigned 7.16 volume
  localparam int VOL_INT_W  = 7;
  localparam int VOL_FRAC_W = 16;
  localparam int DELTA_W    = 24;   // signed per-frame ramp increment
  localparam int RAMP_W     = 21;   // frames left in a ramp
  localparam int TIME_W     = 16;   // clamped ramp time, ms
  localparam int GAIN_W     = 17;   // Q16 fade gain, up to unity
  localparam int MUTE_W     = 16;
  localparam int ATT_W      = 16;
  localparam int ATT_SHIFT  = 15;
  localparam int ATT_DEPTH  = 128;

  // Divider: magnitude of the volume difference over the ramp length
  localparam int DIV_W      = VOL_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // Config bus
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Limits
  localparam logic [VOL_INT_W-1:0] VOL_MAX_INT   = 7'd127;
  localparam logic [VOL_W-1:0]     VOL_FULL      = {VOL_MAX_INT, 16'd0};
  localparam logic [TIME_W-1:0]    TIME_MAX      = 16'd60000;
  localparam logic [GAIN_W-1:0]    GAIN_UNITY    = 17'd65536;
  localparam logic [MUTE_W-1:0]    MUTE_LEN_RST  = 16'd4800;
  localparam logic [GAIN_W-1:0]    FADE_STEP_RST = 17'd66;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE  = 2'd0,
    REQ_SET_VOL = 2'd1,
    REQ_UNPAUSE = 2'd2,
    REQ_IGNORE  = 2'd3
  } rvsm_req_t;

  // Config register indexes
  typedef enum logic {
    REG_MUTE_LEN  = 1'b0,
    REG_FADE_STEP = 1'b1
  } rvsm_reg_t;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_STEP  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_MIX   = 6'b010000,
    ST_OUT   = 6'b100000
  } rvsm_state_t;

  // Commands from the sequencer to the volume unit
  typedef struct packed {
    logic set_vol;
    logic unpause;
    logic step;
    logic scale;
  } rvsm_vol_cmd_t;

  // Status from the volume unit
  typedef struct packed {
    logic div_busy;
  } rvsm_vol_sts_t;

  // Q15 attenuation per integer volume step, 32768 = unity
  localparam logic [ATT_W-1:0] ATT_TABLE [ATT_DEPTH] = '{
    16'd0,     16'd2,     16'd8,     16'd18,    16'd32,    16'd50,    16'd73,    16'd99,
    16'd130,   16'd164,   16'd203,   16'd245,   16'd292,   16'd343,   16'd398,   16'd457,
    16'd520,   16'd587,   16'd658,   16'd733,   16'd812,   16'd895,   16'd983,   16'd1074,
    16'd1170,  16'd1269,  16'd1373,  16'd1481,  16'd1592,  16'd1708,  16'd1828,  16'd1952,
    16'd2080,  16'd2212,  16'd2348,  16'd2488,  16'd2632,  16'd2781,  16'd2933,  16'd3090,
    16'd3250,  16'd3415,  16'd3583,  16'd3756,  16'd3933,  16'd4114,  16'd4298,  16'd4487,
    16'd4680,  16'd4877,  16'd5079,  16'd5284,  16'd5493,  16'd5706,  16'd5924,  16'd6145,
    16'd6371,  16'd6600,  16'd6834,  16'd7072,  16'd7313,  16'd7559,  16'd7809,  16'd8063,
    16'd8321,  16'd8583,  16'd8849,  16'd9119,  16'd9394,  16'd9672,  16'd9954,  16'd10241,
    16'd10531, 16'd10826, 16'd11125, 16'd11427, 16'd11734, 16'd12045, 16'd12360, 16'd12679,
    16'd13002, 16'd13329, 16'd13660, 16'd13995, 16'd14335, 16'd14678, 16'd15025, 16'd15377,
    16'd15732, 16'd16092, 16'd16456, 16'd16823, 16'd17195, 16'd17571, 16'd17951, 16'd18335,
    16'd18723, 16'd19115, 16'd19511, 16'd19911, 16'd20316, 16'd20724, 16'd21136, 16'd21553,
    16'd21974, 16'd22398, 16'd22827, 16'd23260, 16'd23696, 16'd24137, 16'd24582, 16'd25031,
    16'd25484, 16'd25941, 16'd26402, 16'd26868, 16'd27337, 16'd27810, 16'd28288, 16'd28769,
    16'd29255, 16'd29744, 16'd30238, 16'd30736, 16'd31238, 16'd31744, 16'd32254, 16'd32768
  };

endpackage

// ----- src/rvsm_if.sv -----
// Valid/ready channel interfaces for requests and mixed sample frames.
interface rvsm_in_if import rvsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [REQ_W-1:0]           req_type;
  logic                       audio_active;
  logic signed [SAMPLE_W-1:0] lib_left;
  logic signed [SAMPLE_W-1:0] lib_right;
  logic signed [SAMPLE_W-1:0] movie_left;
  logic signed [SAMPLE_W-1:0] movie_right;
  logic signed [WORD_W-1:0]   volume_req;
  logic signed [WORD_W-1:0]   ramp_time;

  modport source (
    output valid, req_type, audio_active, lib_left, lib_right,
           movie_left, movie_right, volume_req, ramp_time,
    input  ready
  );
  modport sink (
    input  valid, req_type, audio_active, lib_left, lib_right,
           movie_left, movie_right, volume_req, ramp_time,
    output ready
  );
endinterface

interface rvsm_out_if import rvsm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;

  modport source (output valid, out_left, out_right, input ready);
  modport sink (input valid, out_left, out_right, output ready);
endinterface

// ----- src/ramped_volume_stereo_mixer.sv -----
// Top level of the ramped-volume stereo mixer: sequencer, config port, lanes, output stage.
// A sample frame passes the step, scale, mix and out states on its way to the output
// register: one step of the volume ramp and fade, one fade multiply, one attenuation
// multiply in each of the two channel lanes, and the saturating add into the output
// register, which waits in the out state until the receiver has taken the last frame.
// The next request is taken back in idle; a frame with audio inactive skips to out.
// A set-volume request with a nonzero ramp time waits in the divide state while the
// 23-step serial divider forms the per-frame ramp increment and writes it back; with
// a zero ramp time it passes the divide state with no divide. Unpause and ignored
// requests, and a set-volume request with audio inactive, are taken without leaving idle.
// Frames with audio inactive give zeros and leave the volume state unchanged.
module ramped_volume_stereo_mixer import rvsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rvsm_in_if.sink               in_ch,
  rvsm_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  rvsm_state_t state_r, state_nxt;

  logic [MUTE_W-1:0]          mute_len_r;
  logic [GAIN_W-1:0]          fade_step_r;
  logic                       active_r;
  logic signed [SAMPLE_W-1:0] lib_l_r, lib_r_r, mov_l_r, mov_r_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_l_r, out_r_r;

  logic                       in_xfer;
  logic                       out_load;
  logic                       cfg_wr;
  rvsm_req_t                  req;
  rvsm_vol_cmd_t              vol_cmd;
  rvsm_vol_sts_t              vol_sts;
  logic [VOL_INT_W-1:0]       att_idx;
  logic [ATT_W-1:0]           att;
  logic                       lane_load;
  logic signed [SAMPLE_W-1:0] lane_l, lane_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign req         = rvsm_req_t'(in_ch.req_type);

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mute_len_r  <= MUTE_LEN_RST;
      fade_step_r <= FADE_STEP_RST;
    end else if (cfg_wr) begin
      if (rvsm_reg_t'(cfg_paddr[2]) == REG_FADE_STEP) begin
        fade_step_r <= cfg_pwdata[GAIN_W-1:0];
      end else begin
        mute_len_r <= cfg_pwdata[MUTE_W-1:0];
      end
    end
  end

  assign cfg_prdata = (rvsm_reg_t'(cfg_paddr[2]) == REG_FADE_STEP) ?
                      {{(CFG_DATA_W-GAIN_W){1'b0}}, fade_step_r} :
                      {{(CFG_DATA_W-MUTE_W){1'b0}}, mute_len_r};

  // Volume unit commands
  always_comb begin
    vol_cmd         = '0;
    vol_cmd.set_vol = in_xfer && (req == REQ_SET_VOL) && in_ch.audio_active;
    vol_cmd.unpause = in_xfer && (req == REQ_UNPAUSE);
    vol_cmd.step    = (state_r == ST_STEP);
    vol_cmd.scale   = (state_r == ST_SCALE);
  end

  rvsm_vol u_vol (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (vol_cmd),
    .volume_req  (in_ch.volume_req),
    .ramp_time   (in_ch.ramp_time),
    .mute_length (mute_len_r),
    .fade_step   (fade_step_r),
    .sts         (vol_sts),
    .att_idx     (att_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (req)
            REQ_SAMPLE:  state_nxt = in_ch.audio_active ? ST_STEP : ST_OUT;
            REQ_SET_VOL: state_nxt = in_ch.audio_active ? ST_DIV : ST_IDLE;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (!vol_sts.div_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_STEP:  state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Captured sample frame
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      active_r <= in_ch.audio_active;
      lib_l_r  <= in_ch.lib_left;
      lib_r_r  <= in_ch.lib_right;
      mov_l_r  <= in_ch.movie_left;
      mov_r_r  <= in_ch.movie_right;
    end
  end

  // Channel lanes share one attenuation value
  assign att       = ATT_TABLE[att_idx];
  assign lane_load = (state_r == ST_MIX);

  rvsm_lane u_lane_l (
    .clk    (clk),
    .load   (lane_load),
    .att    (att),
    .movie  (mov_l_r),
    .lib    (lib_l_r),
    .sample (lane_l)
  );

  rvsm_lane u_lane_r (
    .clk    (clk),
    .load   (lane_load),
    .att    (att),
    .movie  (mov_r_r),
    .lib    (lib_r_r),
    .sample (lane_r)
  );

  // Merge into output register
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_l_r <= active_r ? lane_l : '0;
      out_r_r <= active_r ? lane_r : '0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_l_r;
  assign out_ch.out_right = out_r_r;

endmodule

// ----- src/rvsm_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp increment.
module rvsm_div import rvsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [RAMP_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [DIV_W-1:0]  quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [RAMP_W-1:0]    rem_r;
  logic [RAMP_W-1:0]    dvs_r;
  logic [RAMP_W:0]      shifted;
  logic                 fits;

  // Partial remainder with next dividend bit brought down
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= RAMP_W'(shifted - {1'b0, dvs_r});
      end else begin
        rem_r <= shifted[RAMP_W-1:0];
      end
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign busy     = busy_r | done_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- src/rvsm_vol.sv -----
// Volume ramp, mute window and fade-in state; yields the attenuation index.
module rvsm_vol import rvsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rvsm_vol_cmd_t            cmd,
  input  logic signed [WORD_W-1:0] volume_req,
  input  logic signed [WORD_W-1:0] ramp_time,
  input  logic [MUTE_W-1:0]        mute_length,
  input  logic [GAIN_W-1:0]        fade_step,
  output rvsm_vol_sts_t            sts,
  output logic [VOL_INT_W-1:0]     att_idx
);

  logic [VOL_W-1:0]        cur_vol_r;
  logic [VOL_INT_W-1:0]    tgt_vol_r;
  logic [DELTA_W-1:0]      delta_r;
  logic [RAMP_W-1:0]       ramp_rem_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [GAIN_W-1:0]       gain_inc_r;
  logic [MUTE_W-1:0]       mute_rem_r;
  logic                    div_neg_r;
  logic                    sel_mute_r;
  logic                    sel_fade_r;
  logic [VOL_FRAC_W-1:0]   gain_cap_r;
  logic [VOL_INT_W-1:0]    att_idx_r;

  logic [VOL_INT_W-1:0]    vol_cl;
  logic [TIME_W-1:0]       time_cl;
  logic [DELTA_W-1:0]      diff;
  logic [DIV_W-1:0]        diff_mag;
  logic [RAMP_W-1:0]       ramp_len;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [DIV_W-1:0]        div_quo;
  logic signed [DELTA_W:0] step_sum;
  logic [VOL_W-1:0]        step_vol;
  logic [GAIN_W:0]         gain_sum;
  logic [VOL_W+VOL_FRAC_W-1:0] fade_prod;

  // Clamp requested volume and time
  always_comb begin
    if (volume_req < 32'sd0) begin
      vol_cl = '0;
    end else if (volume_req > 32'sd127) begin
      vol_cl = VOL_MAX_INT;
    end else begin
      vol_cl = volume_req[VOL_INT_W-1:0];
    end
    if (ramp_time < 32'sd0) begin
      time_cl = '0;
    end else if (ramp_time > $signed({16'd0, TIME_MAX})) begin
      time_cl = TIME_MAX;
    end else begin
      time_cl = ramp_time[TIME_W-1:0];
    end
  end

  // Ramp setup: signed distance to the new target, ramp of 32 frames per ms
  assign diff      = {1'b0, vol_cl, 16'd0} - {1'b0, cur_vol_r};
  assign diff_mag  = diff[DELTA_W-1] ? DIV_W'(-diff) : diff[DIV_W-1:0];
  assign ramp_len  = {time_cl, 5'd0};
  assign div_start = cmd.set_vol && (time_cl != '0);

  rvsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_mag),
    .divisor  (ramp_len),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // One ramp step, clamped to the volume range
  always_comb begin
    step_sum = $signed({2'b00, cur_vol_r}) + $signed({delta_r[DELTA_W-1], delta_r});
    if (step_sum[DELTA_W]) begin
      step_vol = '0;
    end else if (step_sum > $signed({2'b00, VOL_FULL})) begin
      step_vol = VOL_FULL;
    end else begin
      step_vol = step_sum[VOL_W-1:0];
    end
  end

  assign gain_sum  = {1'b0, gain_r} + {1'b0, gain_inc_r};
  assign fade_prod = {{VOL_FRAC_W{1'b0}}, cur_vol_r} * {{VOL_W{1'b0}}, gain_cap_r};

  // Volume and fade state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vol_r  <= VOL_FULL;
      tgt_vol_r  <= VOL_MAX_INT;
      delta_r    <= '0;
      ramp_rem_r <= '0;
      gain_r     <= GAIN_UNITY;
      gain_inc_r <= '0;
      mute_rem_r <= '0;
    end else begin
      if (cmd.set_vol) begin
        tgt_vol_r <= vol_cl;
        if (time_cl != '0) begin
          ramp_rem_r <= ramp_len;
        end else begin
          ramp_rem_r <= '0;
          cur_vol_r  <= {vol_cl, 16'd0};
        end
      end
      if (div_done) begin
        delta_r <= div_neg_r ? DELTA_W'(-{1'b0, div_quo}) : {1'b0, div_quo};
      end
      if (cmd.unpause) begin
        gain_r     <= '0;
        gain_inc_r <= fade_step;
        mute_rem_r <= mute_length;
      end
      if (cmd.step) begin
        if (ramp_rem_r != '0) begin
          cur_vol_r  <= step_vol;
          ramp_rem_r <= ramp_rem_r - 1'b1;
        end else begin
          cur_vol_r <= {tgt_vol_r, 16'd0};
        end
        if (mute_rem_r != '0) begin
          mute_rem_r <= mute_rem_r - 1'b1;
        end else if (!gain_r[GAIN_W-1]) begin
          if (gain_sum >= {1'b0, GAIN_UNITY}) begin
            gain_r     <= GAIN_UNITY;
            gain_inc_r <= '0;
          end else begin
            gain_r <= gain_sum[GAIN_W-1:0];
          end
        end
      end
    end
  end

  // Per-frame selection and scaled index
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_neg_r <= diff[DELTA_W-1];
    end
    if (cmd.step) begin
      sel_mute_r <= (mute_rem_r != '0);
      sel_fade_r <= (mute_rem_r == '0) && !gain_r[GAIN_W-1];
      gain_cap_r <= gain_r[VOL_FRAC_W-1:0];
    end
    if (cmd.scale) begin
      if (sel_mute_r) begin
        att_idx_r <= '0;
      end else if (sel_fade_r) begin
        att_idx_r <= fade_prod[VOL_W+VOL_FRAC_W-1:VOL_W+VOL_FRAC_W-VOL_INT_W];
      end else begin
        att_idx_r <= cur_vol_r[VOL_W-1:VOL_FRAC_W];
      end
    end
  end

  assign sts.div_busy = div_busy;
  assign att_idx      = att_idx_r;

endmodule

// ----- src/rvsm_lane.sv -----
// One channel lane: attenuate the movie sample, add library sample, saturate.
module rvsm_lane import rvsm_pkg::*; (
  input  logic                       clk,
  input  logic                       load,
  input  logic [ATT_W-1:0]           att,
  input  logic signed [SAMPLE_W-1:0] movie,
  input  logic signed [SAMPLE_W-1:0] lib,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic signed [ATT_W+SAMPLE_W:0]     prod_r;
  logic signed [ATT_W+SAMPLE_W-ATT_SHIFT:0] scaled;
  logic signed [ATT_W+SAMPLE_W-ATT_SHIFT+1:0] sum;

  // Attenuation product, unsigned 16-bit gain by signed 16-bit sample
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= $signed({{SAMPLE_W{1'b0}}, 1'b0, att}) *
                $signed({{(ATT_W+1){movie[SAMPLE_W-1]}}, movie});
    end
  end

  // Floor shift, add and clamp
  assign scaled = prod_r[ATT_W+SAMPLE_W:ATT_SHIFT];
  assign sum    = $signed({{3{lib[SAMPLE_W-1]}}, lib}) + $signed({scaled[ATT_W+SAMPLE_W-ATT_SHIFT],
                  scaled});

  always_comb begin
    if (sum < -19'sd32768) begin
      sample = -16'sd32768;
    end else if (sum > 19'sd32767) begin
      sample = 16'sd32767;
    end else begin
      sample = sum[SAMPLE_W-1:0];
    end
  end

endmodule
